>>> rtl/core/plp_pkg.sv
// Shared types, register codes and arithmetic helpers for the page layout placer.
package plp_pkg;

   // Item kinds on the request channel
   typedef enum logic {
      PLP_MODE_PLACE = 1'b0,
      PLP_MODE_RESET = 1'b1
   } plp_mode_type;

   // Register indexes on the configuration channel
   localparam int CSR_INDEX_WIDTH = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LEFT_MARGIN  = 4'd0,
      CSR_TOP_MARGIN   = 4'd1,
      CSR_RIGHT_LIMIT  = 4'd2,
      CSR_BOTTOM_LIMIT = 4'd3,
      CSR_ROW_GAP      = 4'd4,
      CSR_COLUMN_GAP   = 4'd5,
      CSR_ROWS_FIRST   = 4'd6,
      CSR_SCALE_Q8     = 4'd7
   } plp_csr_type;

   // Register reset values
   localparam logic [15:0] RST_LEFT_MARGIN  = 16'd72;
   localparam logic [15:0] RST_TOP_MARGIN   = 16'd72;
   localparam logic [15:0] RST_RIGHT_LIMIT  = 16'd540;
   localparam logic [15:0] RST_BOTTOM_LIMIT = 16'd720;
   localparam logic [15:0] RST_ROW_GAP      = 16'd36;
   localparam logic [15:0] RST_COLUMN_GAP   = 16'd36;
   localparam logic        RST_ROWS_FIRST   = 1'b1;
   localparam logic [15:0] RST_SCALE_Q8     = 16'd256;

   // Layout configuration as seen by the placement logic
   typedef struct packed {
      logic [15:0] left_margin;
      logic [15:0] top_margin;
      logic [15:0] right_limit;
      logic [15:0] bottom_limit;
      logic [15:0] row_gap;
      logic [15:0] column_gap;
      logic        rows_first;
      logic [15:0] scale_q8;
   } plp_cfg_type;

   // Scaled item handed to the placement stage
   typedef struct packed {
      plp_mode_type mode;
      logic [15:0]  width;
      logic [15:0]  height;
   } plp_item_type;

   // Scale by unsigned Q8.8, round up, saturate at 16 bits
   function automatic logic [15:0] scale_dim(input logic [15:0] src,
                                             input logic [15:0] scale);
      logic [31:0] prod;
      logic [32:0] rounded;
      logic [24:0] quot;
      prod    = src * scale;
      rounded = {1'b0, prod} + 33'd255;
      quot    = rounded[32:8];
      return (quot > 25'd65535) ? 16'hFFFF : quot[15:0];
   endfunction

   // True when the wrapped signed sum of base and size passes the limit
   function automatic logic overflows(input logic [31:0] base,
                                      input logic [31:0] size,
                                      input logic [15:0] limit);
      logic [31:0] sum;
      sum = base + size;
      return $signed(sum) > $signed({16'b0, limit});
   endfunction

endpackage

>>> rtl/core/plp_if.sv
// Channel interfaces: request, response and configuration write.
interface plp_req_if;
   logic                  valid;
   logic                  ready;
   plp_pkg::plp_mode_type mode;
   logic [15:0]           src_width;
   logic [15:0]           src_height;

   modport source (output valid, mode, src_width, src_height, input ready);
   modport sink   (input valid, mode, src_width, src_height, output ready);
endinterface

interface plp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] dst_x;
   logic signed [31:0] dst_y;
   logic [15:0]        dst_width;
   logic [15:0]        dst_height;
   logic               page_break;

   modport source (output valid, dst_x, dst_y, dst_width, dst_height, page_break,
                   input ready);
   modport sink   (input valid, dst_x, dst_y, dst_width, dst_height, page_break,
                   output ready);
endinterface

interface plp_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [plp_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [15:0]                          data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/plp_placer.sv
// Cursor state, row and column advance, page break and the response register.
module plp_placer (
   input  logic                 clock,
   input  logic                 reset,
   input  plp_pkg::plp_cfg_type cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  plp_pkg::plp_item_type in_item,
   plp_rsp_if.source            rsp_bus
);

   logic [31:0] cursor_x_ff, cursor_x_in;
   logic [31:0] cursor_y_ff, cursor_y_in;
   logic [31:0] extent_ff, extent_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_x_ff, out_y_ff;
   logic [15:0] out_w_ff, out_h_ff;
   logic        out_brk_ff;

   logic [31:0] lm32, tm32, rg32, cg32, w32, h32;
   logic [31:0] row_y, col_x;
   logic [31:0] x_a, y_a, ext_a;
   logic [31:0] pos_x, pos_y;
   logic        at_origin, move, brk, fire;

   // Take a new transaction when the response slot is free or draining
   assign in_ready = !out_valid_ff || rsp_bus.ready;
   assign fire     = in_valid && in_ready;

   // Work out placement and the next cursor
   always_comb begin
      lm32      = {16'b0, cfg.left_margin};
      tm32      = {16'b0, cfg.top_margin};
      rg32      = {16'b0, cfg.row_gap};
      cg32      = {16'b0, cfg.column_gap};
      w32       = {16'b0, in_item.width};
      h32       = {16'b0, in_item.height};
      at_origin = (cursor_x_ff == lm32) && (cursor_y_ff == tm32);
      row_y     = cursor_y_ff + rg32 + extent_ff;
      col_x     = cursor_x_ff + cg32 + extent_ff;

      if (cfg.rows_first) begin
         move  = !at_origin && plp_pkg::overflows(cursor_x_ff, w32, cfg.right_limit);
         brk   = move && plp_pkg::overflows(row_y, h32, cfg.bottom_limit);
         x_a   = move ? lm32 : cursor_x_ff;
         y_a   = move ? row_y : cursor_y_ff;
         ext_a = move ? h32 : extent_ff;
      end else begin
         move  = !at_origin && plp_pkg::overflows(cursor_y_ff, h32, cfg.bottom_limit);
         brk   = move && plp_pkg::overflows(col_x, w32, cfg.right_limit);
         x_a   = move ? col_x : cursor_x_ff;
         y_a   = move ? tm32 : cursor_y_ff;
         ext_a = move ? w32 : extent_ff;
      end

      // A page break sends the rectangle back to the margins
      pos_x = brk ? lm32 : x_a;
      pos_y = brk ? tm32 : y_a;

      // Advance past the rectangle and widen the line extent
      if (cfg.rows_first) begin
         extent_in   = ($signed(h32) > $signed(ext_a)) ? h32 : ext_a;
         cursor_x_in = pos_x + cg32 + w32;
         cursor_y_in = pos_y;
      end else begin
         extent_in   = ($signed(w32) > $signed(ext_a)) ? w32 : ext_a;
         cursor_x_in = pos_x;
         cursor_y_in = pos_y + rg32 + h32;
      end

      // Cursor reset drops back to the margins with an empty line
      if (in_item.mode == plp_pkg::PLP_MODE_RESET) begin
         cursor_x_in = lm32;
         cursor_y_in = tm32;
         extent_in   = 32'd0;
      end

      out_valid_in = in_ready ? (in_valid && (in_item.mode == plp_pkg::PLP_MODE_PLACE))
                              : out_valid_ff;
   end

   // Hold cursor state, advance on every accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= 32'd0;
         cursor_y_ff  <= 32'd0;
         extent_ff    <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            cursor_x_ff <= cursor_x_in;
            cursor_y_ff <= cursor_y_in;
            extent_ff   <= extent_in;
         end
      end
   end

   // Load the response payload
   always_ff @(posedge clock) begin
      if (fire && (in_item.mode == plp_pkg::PLP_MODE_PLACE)) begin
         out_x_ff   <= pos_x;
         out_y_ff   <= pos_y;
         out_w_ff   <= in_item.width;
         out_h_ff   <= in_item.height;
         out_brk_ff <= brk;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.dst_x      = $signed(out_x_ff);
   assign rsp_bus.dst_y      = $signed(out_y_ff);
   assign rsp_bus.dst_width  = out_w_ff;
   assign rsp_bus.dst_height = out_h_ff;
   assign rsp_bus.page_break = out_brk_ff;

endmodule

>>> rtl/core/page_layout_placer_unit.sv
// Top level of the page layout placer: registers, scaling stage and placer.
//
//   channel   direction  handshake     payload
//   req_bus   in         valid/ready   mode, src_width, src_height
//   rsp_bus   out        valid/ready   dst_x, dst_y, dst_width, dst_height, page_break
//   csr_bus   in         valid/ready   index, data (ready always high)
//
// One transaction per cycle sustained while rsp_bus accepts; a placed rectangle is offered
// once it has passed the input register, then the scaling register, then the response
// register. The cursor feedback loop through the placer closes between accepted items.
// Reset is synchronous; no clearing pass.
// Each stage holds while the stage after it is full and stalled, so request
// ready only drops once all three stages are occupied.
module page_layout_placer_unit (
   input logic        clock,
   input logic        reset,
   plp_req_if.sink    req_bus,
   plp_rsp_if.source  rsp_bus,
   plp_csr_if.sink    csr_bus
);

   plp_pkg::plp_cfg_type  cfg_ff, cfg_in;
   logic                  s1_valid_ff, s1_valid_in;
   plp_pkg::plp_item_type s1_item_ff;
   logic                  s2_valid_ff, s2_valid_in;
   plp_pkg::plp_item_type s2_item_ff, s2_item_in;
   logic                  s1_ready, s2_ready, s3_ready;

   // Configuration registers
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            plp_pkg::CSR_LEFT_MARGIN:  cfg_in.left_margin  = csr_bus.data;
            plp_pkg::CSR_TOP_MARGIN:   cfg_in.top_margin   = csr_bus.data;
            plp_pkg::CSR_RIGHT_LIMIT:  cfg_in.right_limit  = csr_bus.data;
            plp_pkg::CSR_BOTTOM_LIMIT: cfg_in.bottom_limit = csr_bus.data;
            plp_pkg::CSR_ROW_GAP:      cfg_in.row_gap      = csr_bus.data;
            plp_pkg::CSR_COLUMN_GAP:   cfg_in.column_gap   = csr_bus.data;
            plp_pkg::CSR_ROWS_FIRST:   cfg_in.rows_first   = csr_bus.data[0];
            plp_pkg::CSR_SCALE_Q8:     cfg_in.scale_q8     = csr_bus.data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_margin  <= plp_pkg::RST_LEFT_MARGIN;
         cfg_ff.top_margin   <= plp_pkg::RST_TOP_MARGIN;
         cfg_ff.right_limit  <= plp_pkg::RST_RIGHT_LIMIT;
         cfg_ff.bottom_limit <= plp_pkg::RST_BOTTOM_LIMIT;
         cfg_ff.row_gap      <= plp_pkg::RST_ROW_GAP;
         cfg_ff.column_gap   <= plp_pkg::RST_COLUMN_GAP;
         cfg_ff.rows_first   <= plp_pkg::RST_ROWS_FIRST;
         cfg_ff.scale_q8     <= plp_pkg::RST_SCALE_Q8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage readiness: a stage loads when empty or when its content moves on
   assign s2_ready      = !s2_valid_ff || s3_ready;
   assign s1_ready      = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;

   always_comb begin
      s1_valid_in       = s1_ready ? req_bus.valid : s1_valid_ff;
      s2_valid_in       = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_item_in.mode   = s1_item_ff.mode;
      s2_item_in.width  = plp_pkg::scale_dim(s1_item_ff.width, cfg_ff.scale_q8);
      s2_item_in.height = plp_pkg::scale_dim(s1_item_ff.height, cfg_ff.scale_q8);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Capture the request, then the scaled sizes
   always_ff @(posedge clock) begin
      if (s1_ready && req_bus.valid) begin
         s1_item_ff.mode   <= req_bus.mode;
         s1_item_ff.width  <= req_bus.src_width;
         s1_item_ff.height <= req_bus.src_height;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_item_ff <= s2_item_in;
      end
   end

   plp_placer u_placer (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (s2_valid_ff),
      .in_ready (s3_ready),
      .in_item  (s2_item_ff),
      .rsp_bus  (rsp_bus)
   );

endmodule

>>> rtl/core/plp_checker.sv
// Port-level checks for the page layout placer, bound to the top level.
module plp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [31:0]                          rsp_dst_x,
   input logic [31:0]                          rsp_dst_y,
   input logic [15:0]                          rsp_dst_width,
   input logic [15:0]                          rsp_dst_height,
   input logic                                 rsp_page_break,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [plp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [15:0]                          csr_data
);

   logic [15:0] left_ff, top_ff;

   // Track the margins from configuration transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= plp_pkg::RST_LEFT_MARGIN;
         top_ff  <= plp_pkg::RST_TOP_MARGIN;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == plp_pkg::CSR_LEFT_MARGIN) left_ff <= csr_data;
         if (csr_index == plp_pkg::CSR_TOP_MARGIN)  top_ff  <= csr_data;
      end
   end

   // A stalled response stays offered with the same payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dst_x) && $stable(rsp_dst_y)
         && $stable(rsp_dst_width) && $stable(rsp_dst_height) && $stable(rsp_page_break))
      else $error("stalled response changed");

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // Requests are only refused when the output is backed up
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without output backpressure");

   // A page break places the rectangle at the margins
   a_break_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_break |-> rsp_dst_x == {16'b0, left_ff}
         && rsp_dst_y == {16'b0, top_ff})
      else $error("page break not placed at margins");

endmodule

bind page_layout_placer_unit plp_checker u_plp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_dst_x      (rsp_bus.dst_x),
   .rsp_dst_y      (rsp_bus.dst_y),
   .rsp_dst_width  (rsp_bus.dst_width),
   .rsp_dst_height (rsp_bus.dst_height),
   .rsp_page_break (rsp_bus.page_break),
   .csr_valid      (csr_bus.valid),
   .csr_ready      (csr_bus.ready),
   .csr_index      (csr_bus.index),
   .csr_data       (csr_bus.data)
);
